FILE: rtl/lwdm_pkg.sv
// ----------------------------------------------------------------------------
// lwdm_pkg
// Shared codes and types for the lock wait deadlock monitor.
// ----------------------------------------------------------------------------
package lwdm_pkg;

    // command codes
    localparam logic [2:0] CMD_ATTEMPT  = 3'd0;
    localparam logic [2:0] CMD_ACQUIRED = 3'd1;
    localparam logic [2:0] CMD_RELEASED = 3'd2;
    localparam logic [2:0] CMD_TICK     = 3'd3;
    localparam logic [2:0] CMD_CHECK    = 3'd4;

    // result kinds
    localparam logic [2:0] KIND_OK       = 3'd0;
    localparam logic [2:0] KIND_FULL     = 3'd1;
    localparam logic [2:0] KIND_NOMATCH  = 3'd2;
    localparam logic [2:0] KIND_NONE     = 3'd3;
    localparam logic [2:0] KIND_TIMEOUT  = 3'd4;
    localparam logic [2:0] KIND_CIRCULAR = 3'd5;
    localparam logic [2:0] KIND_DISABLED = 3'd6;

    // configuration register indexes
    localparam logic [1:0] REG_ENABLE   = 2'd0;
    localparam logic [1:0] REG_WATCHDOG = 2'd1;

    localparam logic [15:0] WATCHDOG_RESET = 16'd5000;

    // compare unit modes
    localparam logic [2:0] MODE_ACQ  = 3'd0; // same thread and lock, not held
    localparam logic [2:0] MODE_REL  = 3'd1; // same thread and lock, held
    localparam logic [2:0] MODE_TMO  = 3'd2; // not held, waited past limit
    localparam logic [2:0] MODE_WAIT = 3'd3; // not held, same thread
    localparam logic [2:0] MODE_OWN  = 3'd4; // held, same lock

    typedef struct packed {
        logic        hit;
        logic [31:0] elapsed;
    } t_match_res;

endpackage

FILE: rtl/lwdm_table.sv
// ----------------------------------------------------------------------------
// lwdm_table
// Entry memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module lwdm_table #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 65
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/lwdm_match.sv
// ----------------------------------------------------------------------------
// lwdm_match
// Shared compare unit: tests one table entry against the current search.
// ----------------------------------------------------------------------------
module lwdm_match
    import lwdm_pkg::*;
#(
    parameter int THREAD_BITS = 8,
    parameter int LOCK_BITS   = 8
) (
    input  logic [2:0]             i_mode,
    input  logic [THREAD_BITS-1:0] i_key_thr,
    input  logic [LOCK_BITS-1:0]   i_key_lck,
    input  logic [31:0]            i_now,
    input  logic [THREAD_BITS-1:0] i_thr,
    input  logic [LOCK_BITS-1:0]   i_lck,
    input  logic [31:0]            i_start,
    input  logic [15:0]            i_lim,
    input  logic                   i_held,
    output t_match_res             o_res
);

    logic [31:0] elapsed;
    logic        thr_eq;
    logic        lck_eq;

    assign elapsed = i_now - i_start;
    assign thr_eq  = (i_thr == i_key_thr);
    assign lck_eq  = (i_lck == i_key_lck);

    always_comb begin
        o_res.elapsed = elapsed;
        case (i_mode)
            MODE_ACQ:  o_res.hit = thr_eq && lck_eq && !i_held;
            MODE_REL:  o_res.hit = thr_eq && lck_eq && i_held;
            MODE_TMO:  o_res.hit = !i_held && (elapsed > {16'd0, i_lim});
            MODE_WAIT: o_res.hit = thr_eq && !i_held;
            MODE_OWN:  o_res.hit = lck_eq && i_held;
            default:   o_res.hit = 1'b0;
        endcase
    end

endmodule

FILE: rtl/lock_wait_deadlock_monitor_unit.sv
// ----------------------------------------------------------------------------
// lock_wait_deadlock_monitor_unit
// Lock wait table with watchdog timeout scan and two-thread circular wait check.
// ----------------------------------------------------------------------------
// Attempt, tick without scan and disabled commands finish in the decode state.
// Searches visit entries one at a time through the single table read port;
// release also moves each later entry down one place. A check walks the stored
// entries in an outer walk and runs up to four searches for each waiting one.
// One command at a time; busy stays high until the result strobe is loaded.
// Synchronous reset empties the table, clears clock and counters, enable=1.
// ----------------------------------------------------------------------------
module lock_wait_deadlock_monitor_unit
    import lwdm_pkg::*;
#(
    parameter int TABLE_ENTRIES = 16,
    parameter int THREAD_BITS   = 8,
    parameter int LOCK_BITS     = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    input  logic [2:0]  i_command,
    input  logic [7:0]  i_thread_id,
    input  logic [7:0]  i_lock_id,
    input  logic [15:0] i_max_wait_ms,
    output logic        o_done,
    output logic [2:0]  o_kind,
    output logic [7:0]  o_first_thread,
    output logic [7:0]  o_first_lock,
    output logic [7:0]  o_second_thread,
    output logic [7:0]  o_second_lock,
    output logic [31:0] o_wait_ms,
    output logic [31:0] o_detection_count
);

    localparam int IW = $clog2(TABLE_ENTRIES);
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam int TB = THREAD_BITS;
    localparam int LB = LOCK_BITS;

    typedef struct packed {
        logic [TB-1:0] thr;
        logic [LB-1:0] lck;
        logic [31:0]   start;
        logic [15:0]   lim;
        logic          held;
    } t_entry;

    localparam int EW = $bits(t_entry);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DEC  = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_EV   = 3'd3;
    localparam logic [2:0] S_KRD  = 3'd4;
    localparam logic [2:0] S_KEV  = 3'd5;
    localparam logic [2:0] S_SHRD = 3'd6;
    localparam logic [2:0] S_SHWR = 3'd7;

    // search phases
    localparam logic [2:0] P_ACQ  = 3'd0;
    localparam logic [2:0] P_TMO  = 3'd1;
    localparam logic [2:0] P_NW   = 3'd2;
    localparam logic [2:0] P_OWN1 = 3'd3;
    localparam logic [2:0] P_WT2  = 3'd4;
    localparam logic [2:0] P_OWN2 = 3'd5;

    logic [2:0]    r_state, n_state;
    logic [2:0]    r_phase, n_phase;
    logic [2:0]    r_mode, n_mode;
    logic          r_up, n_up;
    logic [IW-1:0] r_idx, n_idx;
    logic [IW-1:0] r_k, n_k;
    logic [CW-1:0] r_count, n_count;
    logic [31:0]   r_now, n_now;
    logic [15:0]   r_beat, n_beat;
    logic [31:0]   r_det, n_det;
    logic          r_en, n_en;
    logic [15:0]   r_wdt, n_wdt;
    logic [2:0]    r_cmd, n_cmd;
    logic [TB-1:0] r_thr, n_thr;
    logic [LB-1:0] r_lck, n_lck;
    logic [15:0]   r_lim, n_lim;
    logic [TB-1:0] r_w, n_w;
    logic [LB-1:0] r_wl, n_wl;
    logic [TB-1:0] r_o, n_o;

    logic          r_done;
    logic [2:0]    r_kind;
    logic [7:0]    r_t1, r_l1, r_t2, r_l2;
    logic [31:0]   r_wait;

    logic          mem_we;
    logic [IW-1:0] mem_waddr;
    t_entry        mem_wdata;
    logic [IW-1:0] mem_raddr;
    t_entry        mem_rdata;
    t_match_res    mres;

    logic          f_en;
    logic [2:0]    f_kind;
    logic [7:0]    f_t1, f_l1, f_t2, f_l2;
    logic [31:0]   f_wait;

    logic          last;
    logic          k_more;
    logic          sh_more;
    logic [15:0]   half;
    logic [15:0]   beat_inc;

    lwdm_table #(
        .DEPTH (TABLE_ENTRIES),
        .WIDTH (EW)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    lwdm_match #(
        .THREAD_BITS (TB),
        .LOCK_BITS   (LB)
    ) u_match (
        .i_mode    (r_mode),
        .i_key_thr (r_thr),
        .i_key_lck (r_lck),
        .i_now     (r_now),
        .i_thr     (mem_rdata.thr),
        .i_lck     (mem_rdata.lck),
        .i_start   (mem_rdata.start),
        .i_lim     (mem_rdata.lim),
        .i_held    (mem_rdata.held),
        .o_res     (mres)
    );

    assign busy     = (r_state != S_IDLE);
    assign last     = r_up ? ((CW'(r_idx) + CW'(1)) == r_count) : (r_idx == '0);
    assign k_more   = (CW'(r_k) + CW'(1)) < r_count;
    assign sh_more  = (CW'(r_idx) + CW'(1)) < r_count;
    assign half     = (r_wdt[15:1] == 15'd0) ? 16'd1 : {1'b0, r_wdt[15:1]};
    assign beat_inc = r_beat + 16'd1;

    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        n_mode  = r_mode;
        n_up    = r_up;
        n_idx   = r_idx;
        n_k     = r_k;
        n_count = r_count;
        n_now   = r_now;
        n_beat  = r_beat;
        n_det   = r_det;
        n_en    = r_en;
        n_wdt   = r_wdt;
        n_cmd   = r_cmd;
        n_thr   = r_thr;
        n_lck   = r_lck;
        n_lim   = r_lim;
        n_w     = r_w;
        n_wl    = r_wl;
        n_o     = r_o;

        mem_we    = 1'b0;
        mem_waddr = r_idx;
        mem_wdata = mem_rdata;
        mem_raddr = r_idx;

        f_en   = 1'b0;
        f_kind = KIND_OK;
        f_t1   = '0;
        f_l1   = '0;
        f_t2   = '0;
        f_l2   = '0;
        f_wait = '0;

        if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_ENABLE:   n_en  = i_cfg_data[0];
                REG_WATCHDOG: n_wdt = i_cfg_data;
                default:      ;
            endcase
        end

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_cmd   = i_command;
                    n_thr   = TB'(i_thread_id);
                    n_lck   = LB'(i_lock_id);
                    n_lim   = i_max_wait_ms;
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                if (!r_en) begin
                    f_en   = 1'b1;
                    f_kind = KIND_DISABLED;
                end else begin
                    case (r_cmd)
                        CMD_ATTEMPT: begin
                            f_en = 1'b1;
                            if (r_count >= CW'(TABLE_ENTRIES)) begin
                                f_kind = KIND_FULL;
                            end else begin
                                mem_we          = 1'b1;
                                mem_waddr       = r_count[IW-1:0];
                                mem_wdata.thr   = r_thr;
                                mem_wdata.lck   = r_lck;
                                mem_wdata.start = r_now;
                                mem_wdata.lim   = r_lim;
                                mem_wdata.held  = 1'b0;
                                n_count         = r_count + CW'(1);
                            end
                        end
                        CMD_ACQUIRED, CMD_RELEASED: begin
                            if (r_count == '0) begin
                                f_en   = 1'b1;
                                f_kind = KIND_NOMATCH;
                            end else begin
                                n_phase = P_ACQ;
                                n_mode  = (r_cmd == CMD_RELEASED) ? MODE_REL : MODE_ACQ;
                                n_up    = 1'b0;
                                n_idx   = IW'(r_count - CW'(1));
                                n_state = S_RD;
                            end
                        end
                        CMD_TICK: begin
                            n_now = r_now + 32'd1;
                            if (beat_inc >= half) begin
                                n_beat = '0;
                                if (r_count == '0) begin
                                    f_en = 1'b1;
                                end else begin
                                    n_phase = P_TMO;
                                    n_mode  = MODE_TMO;
                                    n_up    = 1'b1;
                                    n_idx   = '0;
                                    n_state = S_RD;
                                end
                            end else begin
                                n_beat = beat_inc;
                                f_en   = 1'b1;
                            end
                        end
                        CMD_CHECK: begin
                            if (r_count == '0) begin
                                f_en   = 1'b1;
                                f_kind = KIND_NONE;
                            end else begin
                                n_phase = P_TMO;
                                n_mode  = MODE_TMO;
                                n_up    = 1'b1;
                                n_idx   = '0;
                                n_state = S_RD;
                            end
                        end
                        default: f_en = 1'b1;
                    endcase
                end
            end
            S_RD: begin
                n_state = S_EV;
            end
            S_EV: begin
                // step on by default; hit and end-of-table arms override
                n_idx   = r_up ? (r_idx + IW'(1)) : (r_idx - IW'(1));
                n_state = S_RD;
                case (r_phase)
                    P_ACQ: begin
                        if (mres.hit) begin
                            n_idx = r_idx;
                            if (r_cmd == CMD_ACQUIRED) begin
                                mem_we         = 1'b1;
                                mem_wdata.held = 1'b1;
                                f_en           = 1'b1;
                            end else begin
                                n_state = S_SHRD;
                            end
                        end else if (last) begin
                            f_en   = 1'b1;
                            f_kind = KIND_NOMATCH;
                        end
                    end
                    P_TMO: begin
                        if (mres.hit) begin
                            f_en   = 1'b1;
                            f_kind = KIND_TIMEOUT;
                            f_t1   = 8'(mem_rdata.thr);
                            f_l1   = 8'(mem_rdata.lck);
                            f_wait = mres.elapsed;
                            if (r_cmd == CMD_TICK) begin
                                n_det = r_det + 32'd1;
                            end
                        end else if (last) begin
                            if (r_cmd == CMD_TICK) begin
                                f_en = 1'b1;
                            end else begin
                                n_k     = '0;
                                n_state = S_KRD;
                            end
                        end
                    end
                    default: begin
                        // circular wait chain: NW, OWN1, WT2, OWN2
                        if (mres.hit && !(r_phase == P_NW && r_idx != r_k)
                                && !(r_phase == P_OWN2 && mem_rdata.thr != r_w)) begin
                            n_up  = 1'b0;
                            n_idx = IW'(r_count - CW'(1));
                            case (r_phase)
                                P_NW: begin
                                    n_phase = P_OWN1;
                                    n_mode  = MODE_OWN;
                                    n_lck   = r_wl;
                                end
                                P_OWN1: begin
                                    n_phase = P_WT2;
                                    n_mode  = MODE_WAIT;
                                    n_o     = mem_rdata.thr;
                                    n_thr   = mem_rdata.thr;
                                end
                                P_WT2: begin
                                    n_phase = P_OWN2;
                                    n_mode  = MODE_OWN;
                                    n_lck   = mem_rdata.lck;
                                end
                                default: begin
                                    f_en   = 1'b1;
                                    f_kind = KIND_CIRCULAR;
                                    f_t1   = 8'(r_w);
                                    f_l1   = 8'(r_wl);
                                    f_t2   = 8'(r_o);
                                    f_l2   = 8'(r_lck);
                                end
                            endcase
                        end else if (mres.hit || last) begin
                            if (k_more) begin
                                n_k     = r_k + IW'(1);
                                n_state = S_KRD;
                            end else begin
                                f_en   = 1'b1;
                                f_kind = KIND_NONE;
                            end
                        end
                    end
                endcase
            end
            S_KRD: begin
                mem_raddr = r_k;
                n_state   = S_KEV;
            end
            S_KEV: begin
                if (mem_rdata.held) begin
                    if (k_more) begin
                        n_k     = r_k + IW'(1);
                        n_state = S_KRD;
                    end else begin
                        f_en   = 1'b1;
                        f_kind = KIND_NONE;
                    end
                end else begin
                    n_w     = mem_rdata.thr;
                    n_wl    = mem_rdata.lck;
                    n_thr   = mem_rdata.thr;
                    n_phase = P_NW;
                    n_mode  = MODE_WAIT;
                    n_up    = 1'b0;
                    n_idx   = IW'(r_count - CW'(1));
                    n_state = S_RD;
                end
            end
            S_SHRD: begin
                // compaction: move entry idx+1 down to idx
                if (sh_more) begin
                    mem_raddr = r_idx + IW'(1);
                    n_state   = S_SHWR;
                end else begin
                    n_count = r_count - CW'(1);
                    f_en    = 1'b1;
                end
            end
            S_SHWR: begin
                mem_we  = 1'b1;
                n_idx   = r_idx + IW'(1);
                n_state = S_SHRD;
            end
            default: n_state = S_IDLE;
        endcase

        if (f_en) begin
            n_state = S_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_now   <= '0;
            r_beat  <= '0;
            r_det   <= '0;
            r_en    <= 1'b1;
            r_wdt   <= WATCHDOG_RESET;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_now   <= n_now;
            r_beat  <= n_beat;
            r_det   <= n_det;
            r_en    <= n_en;
            r_wdt   <= n_wdt;
            r_done  <= f_en;
        end
    end

    always_ff @(posedge i_clk) begin
        r_phase <= n_phase;
        r_mode  <= n_mode;
        r_up    <= n_up;
        r_idx   <= n_idx;
        r_k     <= n_k;
        r_cmd   <= n_cmd;
        r_thr   <= n_thr;
        r_lck   <= n_lck;
        r_lim   <= n_lim;
        r_w     <= n_w;
        r_wl    <= n_wl;
        r_o     <= n_o;
        if (f_en) begin
            r_kind <= f_kind;
            r_t1   <= f_t1;
            r_l1   <= f_l1;
            r_t2   <= f_t2;
            r_l2   <= f_l2;
            r_wait <= f_wait;
        end
    end

    assign o_done            = r_done;
    assign o_kind            = r_kind;
    assign o_first_thread    = r_t1;
    assign o_first_lock      = r_l1;
    assign o_second_thread   = r_t2;
    assign o_second_lock     = r_l2;
    assign o_wait_ms         = r_wait;
    assign o_detection_count = r_det;

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while busy");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_ENTRIES))
        else $error("entry count beyond table size");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy && !o_done))
        else $error("accepted command did not make the unit busy");

    a_det_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_det != $past(r_det)) |-> (o_kind == KIND_TIMEOUT || !o_done))
        else $error("detection count changed without timeout");

endmodule

FILE: tb/lwdm_checker.sv
// ----------------------------------------------------------------------------
// lwdm_checker
// Watches the command, result and register ports of the lock wait deadlock
// monitor, predicts every result from its own copy of the table and compares.
// ----------------------------------------------------------------------------
module lwdm_checker
    import lwdm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    input  logic [2:0]  i_command,
    input  logic [7:0]  i_thread_id,
    input  logic [7:0]  i_lock_id,
    input  logic [15:0] i_max_wait_ms,
    input  logic        o_done,
    input  logic [2:0]  o_kind,
    input  logic [7:0]  o_first_thread,
    input  logic [7:0]  o_first_lock,
    input  logic [7:0]  o_second_thread,
    input  logic [7:0]  o_second_lock,
    input  logic [31:0] o_wait_ms,
    input  logic [31:0] o_detection_count,
    output int          o_errors,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 16;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  first_thread;
        logic [7:0]  first_lock;
        logic [7:0]  second_thread;
        logic [7:0]  second_lock;
        logic [31:0] wait_ms;
        logic [31:0] detections;
    } t_verdict;

    logic [7:0]  tbl_thread [DEPTH];
    logic [7:0]  tbl_lock   [DEPTH];
    logic [31:0] tbl_start  [DEPTH];
    logic [15:0] tbl_limit  [DEPTH];
    logic        tbl_held   [DEPTH];
    int          tbl_used;
    logic [31:0] clock_ms;
    logic [15:0] beat;
    logic [31:0] detections;
    logic        enabled;
    logic [15:0] period_ms;

    t_verdict verdict_q[$];
    int       errors;

    assign o_errors  = errors;
    assign o_pending = verdict_q.size();

    function automatic int newest_waiting(logic [7:0] t);
        for (int i = tbl_used - 1; i >= 0; i--)
            if (!tbl_held[i] && tbl_thread[i] == t) return i;
        return -1;
    endfunction

    function automatic int newest_owner(logic [7:0] l);
        for (int i = tbl_used - 1; i >= 0; i--)
            if (tbl_held[i] && tbl_lock[i] == l) return i;
        return -1;
    endfunction

    function automatic int first_overdue();
        for (int i = 0; i < tbl_used; i++)
            if (!tbl_held[i] && (clock_ms - tbl_start[i]) > {16'd0, tbl_limit[i]}) return i;
        return -1;
    endfunction

    function automatic void fill_timeout(ref t_verdict v, input int i);
        v.kind         = KIND_TIMEOUT;
        v.first_thread = tbl_thread[i];
        v.first_lock   = tbl_lock[i];
        v.wait_ms      = clock_ms - tbl_start[i];
    endfunction

    // advances the shadow table by one command and returns what the block answers
    function automatic t_verdict lock_event(logic [2:0] cmd, logic [7:0] t, logic [7:0] l,
                                            logic [15:0] lim);
        t_verdict v;
        int       hit;
        int       own;
        int       ow;
        int       own2;
        logic     want;
        logic [15:0] half;
        v = '0;
        if (!enabled) begin
            v.kind = KIND_DISABLED;
        end else if (cmd == CMD_ATTEMPT) begin
            if (tbl_used >= DEPTH) begin
                v.kind = KIND_FULL;
            end else begin
                tbl_thread[tbl_used] = t;
                tbl_lock[tbl_used]   = l;
                tbl_start[tbl_used]  = clock_ms;
                tbl_limit[tbl_used]  = lim;
                tbl_held[tbl_used]   = 1'b0;
                tbl_used++;
            end
        end else if (cmd == CMD_ACQUIRED || cmd == CMD_RELEASED) begin
            want = (cmd == CMD_RELEASED);
            hit = -1;
            for (int i = tbl_used - 1; i >= 0; i--)
                if (hit < 0 && tbl_thread[i] == t && tbl_lock[i] == l && tbl_held[i] == want)
                    hit = i;
            if (hit < 0) begin
                v.kind = KIND_NOMATCH;
            end else if (cmd == CMD_ACQUIRED) begin
                tbl_held[hit] = 1'b1;
            end else begin
                for (int k = hit; k + 1 < tbl_used; k++) begin
                    tbl_thread[k] = tbl_thread[k+1];
                    tbl_lock[k]   = tbl_lock[k+1];
                    tbl_start[k]  = tbl_start[k+1];
                    tbl_limit[k]  = tbl_limit[k+1];
                    tbl_held[k]   = tbl_held[k+1];
                end
                tbl_used--;
            end
        end else if (cmd == CMD_TICK) begin
            half = period_ms >> 1;
            if (half == 16'd0) half = 16'd1;
            clock_ms++;
            beat++;
            if (beat >= half) begin
                beat = '0;
                hit = first_overdue();
                if (hit >= 0) begin
                    detections++;
                    fill_timeout(v, hit);
                end
            end
        end else if (cmd == CMD_CHECK) begin
            hit = first_overdue();
            if (hit >= 0) begin
                fill_timeout(v, hit);
            end else begin
                v.kind = KIND_NONE;
                for (int k = 0; k < tbl_used && v.kind == KIND_NONE; k++) begin
                    if (!tbl_held[k] && newest_waiting(tbl_thread[k]) == k) begin
                        own = newest_owner(tbl_lock[k]);
                        ow  = (own < 0) ? -1 : newest_waiting(tbl_thread[own]);
                        own2 = (ow < 0) ? -1 : newest_owner(tbl_lock[ow]);
                        if (own2 >= 0 && tbl_thread[own2] == tbl_thread[k]) begin
                            v.kind          = KIND_CIRCULAR;
                            v.first_thread  = tbl_thread[k];
                            v.first_lock    = tbl_lock[k];
                            v.second_thread = tbl_thread[own];
                            v.second_lock   = tbl_lock[ow];
                        end
                    end
                end
            end
        end
        v.detections = detections;
        return v;
    endfunction

    task automatic field_check(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_verdict want;
        if (!i_rst_n) begin
            tbl_used   <= 0;
            clock_ms   <= '0;
            beat       <= '0;
            detections <= '0;
            enabled    <= 1'b1;
            period_ms  <= WATCHDOG_RESET;
            verdict_q.delete();
            errors     <= 0;
        end else begin
            if (o_done) begin
                if (verdict_q.size() == 0) begin
                    errors++;
                    $display("%0t: result with nothing expected, kind %0d", $time, o_kind);
                end else begin
                    want = verdict_q.pop_front();
                    field_check("kind", 32'(want.kind), 32'(o_kind));
                    field_check("first_thread", 32'(want.first_thread), 32'(o_first_thread));
                    field_check("first_lock", 32'(want.first_lock), 32'(o_first_lock));
                    field_check("second_thread", 32'(want.second_thread),
                                32'(o_second_thread));
                    field_check("second_lock", 32'(want.second_lock), 32'(o_second_lock));
                    field_check("wait_ms", want.wait_ms, o_wait_ms);
                    field_check("detection_count", want.detections, o_detection_count);
                end
            end
            if (start && !busy)
                verdict_q.insert(verdict_q.size(), lock_event(i_command, i_thread_id,
                                                              i_lock_id, i_max_wait_ms));
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_ENABLE) enabled = i_cfg_data[0];
                else if (i_cfg_idx == REG_WATCHDOG) period_ms = i_cfg_data;
            end
        end
    end

endmodule

FILE: tb/tb_lock_wait_deadlock_monitor_unit.sv
// ----------------------------------------------------------------------------
// tb_lock_wait_deadlock_monitor_unit
// Drives lock events, ticks and checks into the monitor under several
// watchdog periods and enable settings; the checker scores every result.
// ----------------------------------------------------------------------------
module tb_lock_wait_deadlock_monitor_unit;
    import lwdm_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 40000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = '0;
    logic [15:0] i_cfg_data = '0;
    logic [2:0]  i_command = '0;
    logic [7:0]  i_thread_id = '0;
    logic [7:0]  i_lock_id = '0;
    logic [15:0] i_max_wait_ms = '0;
    logic        o_done;
    logic [2:0]  o_kind;
    logic [7:0]  o_first_thread, o_first_lock, o_second_thread, o_second_lock;
    logic [31:0] o_wait_ms, o_detection_count;
    int          fail_count;
    int          pending;
    int          quiet_cycles = 0;
    logic        no_idle = 1'b0;
    logic [15:0] recent_pairs[$];

    always #6 i_clk = ~i_clk;

    lock_wait_deadlock_monitor_unit u_top (.*);

    lwdm_checker u_checker (.*, .o_errors(fail_count), .o_pending(pending));

    always @(posedge i_clk) begin
        if ((start && !busy) || o_done || !i_rst_n) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // one transfer; start is left high so a back-to-back command needs no toggle
    task automatic issue(logic [2:0] cmd, logic [7:0] t, logic [7:0] l, logic [15:0] lim);
        int gap;
        gap = no_idle ? 0 : $urandom_range(13);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start         <= 1'b1;
        i_command     <= cmd;
        i_thread_id   <= t;
        i_lock_id     <= l;
        i_max_wait_ms <= lim;
        if (cmd == CMD_ATTEMPT) recent_pairs.insert(recent_pairs.size(), {t, l});
        if (recent_pairs.size() > 24) void'(recent_pairs.pop_front());
        forever begin
            @(negedge i_clk);
            if (!busy) break;
        end
        @(posedge i_clk);
    endtask

    // quiesce, then program a register
    task automatic set_reg(logic [1:0] idx, logic [15:0] data);
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic random_event();
        int          sel;
        logic [7:0]  t, l;
        logic [15:0] lim;
        logic [15:0] pair;
        sel = $urandom_range(99);
        if ($urandom_range(9) == 0) begin
            t = 8'($urandom); l = 8'($urandom);
        end else begin
            t = 8'($urandom_range(3)); l = 8'($urandom_range(3));
        end
        lim = ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(30));
        if (sel >= 25 && sel < 65 && recent_pairs.size() > 0 && $urandom_range(3) != 0) begin
            pair = recent_pairs[$urandom_range(recent_pairs.size() - 1)];
            t = pair[15:8]; l = pair[7:0];
        end
        if (sel < 25)      issue(CMD_ATTEMPT, t, l, lim);
        else if (sel < 45) issue(CMD_ACQUIRED, t, l, lim);
        else if (sel < 65) issue(CMD_RELEASED, t, l, lim);
        else if (sel < 85) issue(CMD_TICK, t, l, lim);
        else if (sel < 97) issue(CMD_CHECK, t, l, lim);
        else               issue(3'($urandom_range(5, 7)), t, l, lim);
    endtask

    initial begin
        logic [15:0] periods[8];
        periods = '{16'd5000, 16'd2, 16'd3, 16'd0, 16'd1, 16'd7, 16'd65535, 16'd12};
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, no-match paths, timeout, circular waits
        issue(CMD_ATTEMPT, 8'd0, 8'd0, 16'd0);
        issue(CMD_ATTEMPT, 8'd255, 8'd255, 16'hFFFF);
        issue(CMD_ACQUIRED, 8'd255, 8'd0, 16'd0);
        issue(CMD_ACQUIRED, 8'd255, 8'd255, 16'd0);
        issue(CMD_RELEASED, 8'd255, 8'd255, 16'd0);
        issue(CMD_RELEASED, 8'd255, 8'd255, 16'd0);
        issue(CMD_TICK, 8'd0, 8'd0, 16'd0);
        issue(CMD_CHECK, 8'd0, 8'd0, 16'd0);
        issue(CMD_RELEASED, 8'd0, 8'd0, 16'd0);
        issue(CMD_ACQUIRED, 8'd0, 8'd0, 16'd0);
        issue(CMD_RELEASED, 8'd0, 8'd0, 16'd0);
        issue(CMD_ATTEMPT, 8'd1, 8'd1, 16'hFFFF);
        issue(CMD_ACQUIRED, 8'd1, 8'd1, 16'd0);
        issue(CMD_ATTEMPT, 8'd2, 8'd2, 16'hFFFF);
        issue(CMD_ACQUIRED, 8'd2, 8'd2, 16'd0);
        issue(CMD_ATTEMPT, 8'd1, 8'd2, 16'hFFFF);
        issue(CMD_ATTEMPT, 8'd2, 8'd1, 16'hFFFF);
        issue(CMD_CHECK, 8'd0, 8'd0, 16'd0);
        // a thread waiting on a lock it already holds
        issue(CMD_ATTEMPT, 8'd3, 8'd3, 16'hFFFF);
        issue(CMD_ACQUIRED, 8'd3, 8'd3, 16'd0);
        issue(CMD_ATTEMPT, 8'd3, 8'd3, 16'hFFFF);
        issue(CMD_CHECK, 8'd0, 8'd0, 16'd0);
        issue(3'd5, 8'd0, 8'd0, 16'd0);
        issue(3'd7, 8'd255, 8'd255, 16'hFFFF);

        // beat counter runs high under the long period, then the period drops
        set_reg(REG_WATCHDOG, 16'd40);
        repeat (15) issue(CMD_TICK, 8'd0, 8'd0, 16'd0);

        for (int phase = 0; phase < 8; phase++) begin
            set_reg(REG_WATCHDOG, periods[phase]);
            if (phase == 3) set_reg(2'd2, 16'hFFFF);
            if (phase == 5) set_reg(2'd3, 16'h0000);
            no_idle = (phase % 3 == 1);
            for (int n = 0; n < 125; n++) begin
                random_event();
                if (n == 60) begin
                    // hold off until the block has answered everything
                    start <= 1'b0;
                    @(posedge i_clk);
                    while (pending != 0) @(posedge i_clk);
                end
            end
            if (phase == 2) begin
                set_reg(REG_ENABLE, 16'hFFFE);
                repeat (20) random_event();
                set_reg(REG_ENABLE, 16'h0001);
            end
        end

        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
